// ===== design/bfa_pkg.sv =====
`timescale 1ns / 1ps

package bfa_pkg;

    // Map geometry
    localparam int unsigned NUM_BLOCKS  = 32768;
    localparam int unsigned BLOCK_BYTES = 4096;
    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned MAP_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WORD_AW     = $clog2(MAP_WORDS);
    localparam int unsigned BIT_W       = $clog2(WORD_BITS);
    localparam int unsigned BLK_W       = WORD_AW + BIT_W;

    // Field widths
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned BLK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int unsigned BIDX_W      = ADDR_W - BLK_SHIFT;
    localparam int unsigned XW          = (BIDX_W + 1 > BLK_W) ? BIDX_W + 1 : BLK_W;

    typedef enum logic [1:0] {
        ACT_ALLOC    = 2'd0,
        ACT_FREE     = 2'd1,
        ACT_REG_FREE = 2'd2,
        ACT_REG_USED = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_REGION,
        ST_FIX_RD,
        ST_FIX_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 we;
        logic [WORD_AW-1:0]   waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [WORD_AW-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] frame;
        logic [CNT_W-1:0]  used;
    } t_result;

endpackage

// ===== design/bfa_map_ram.sv =====
`timescale 1ns / 1ps

module bfa_map_ram (
    input  logic                          i_clk,
    input  bfa_pkg::t_mem_req             i_req,
    output logic [bfa_pkg::WORD_BITS-1:0] o_rdata
);

    logic [bfa_pkg::WORD_BITS-1:0] r_mem [bfa_pkg::MAP_WORDS];
    logic [bfa_pkg::WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bfa_engine.sv =====
`timescale 1ns / 1ps

module bfa_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bfa_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic [bfa_pkg::ADDR_W-1:0]    i_address,
    input  logic [bfa_pkg::ADDR_W-1:0]    i_size_bytes,
    output logic                          o_res_valid,
    input  logic                          i_res_ack,
    output bfa_pkg::t_result              o_res,
    output bfa_pkg::t_mem_req             o_mem_req,
    input  logic [bfa_pkg::WORD_BITS-1:0] i_mem_rdata
);

    localparam logic [bfa_pkg::WORD_BITS-1:0] ONES = '1;

    bfa_pkg::t_state                 r_state, n_state;
    logic [bfa_pkg::WORD_AW-1:0]     r_fill;
    logic [bfa_pkg::CNT_W-1:0]       r_eff;
    logic [bfa_pkg::CNT_W-1:0]       r_count;
    bfa_pkg::t_action                r_act;
    logic [bfa_pkg::BIDX_W-1:0]      r_start;
    logic [bfa_pkg::BIDX_W:0]        r_end;
    logic                            r_nz;
    logic [bfa_pkg::WORD_AW-1:0]     r_first, r_last, r_rd, r_cw;
    logic [bfa_pkg::BIT_W-1:0]       r_lo, r_hi;
    logic                            r_qv;
    logic                            r_status;
    logic [bfa_pkg::ADDR_W-1:0]      r_frame;

    // Effective total of a new configuration value
    logic [bfa_pkg::CNT_W-1:0]       cfg_eff;

    // Request set-up
    bfa_pkg::t_action                in_act;
    logic [bfa_pkg::BIDX_W-1:0]      in_start, in_amount;

    // Range preparation
    logic [bfa_pkg::XW-1:0]          eff_x, end_x, endc, lastb, start_x;
    logic                            nonempty, fix_zero;
    logic [bfa_pkg::WORD_AW-1:0]     first_w;

    // Word processing
    logic [bfa_pkg::BIT_W-1:0]       lo, hi, hit_idx;
    logic [bfa_pkg::BIT_W:0]         k;
    logic [bfa_pkg::WORD_BITS-1:0]   mask, cand, iso, alloc_word, reg_word;
    logic                            found, last_word;
    logic [bfa_pkg::CNT_W:0]         up_sum;
    logic [bfa_pkg::CNT_W-1:0]       cnt_up, cnt_dn;

    assign cfg_eff = (32'(i_cfg_wr_data) > bfa_pkg::NUM_BLOCKS)
                   ? bfa_pkg::CNT_W'(bfa_pkg::NUM_BLOCKS) : i_cfg_wr_data;

    assign in_act    = bfa_pkg::t_action'(i_action);
    assign in_start  = i_address[bfa_pkg::ADDR_W-1:bfa_pkg::BLK_SHIFT];
    assign in_amount = (in_act == bfa_pkg::ACT_FREE)
                     ? bfa_pkg::BIDX_W'(1) : i_size_bytes[bfa_pkg::ADDR_W-1:bfa_pkg::BLK_SHIFT];

    // The last block touched is one below the end clamped to the total.
    assign eff_x    = bfa_pkg::XW'(r_eff);
    assign end_x    = bfa_pkg::XW'(r_end);
    assign start_x  = bfa_pkg::XW'(r_start);
    assign endc     = (r_act == bfa_pkg::ACT_ALLOC || end_x > eff_x) ? eff_x : end_x;
    assign lastb    = endc - bfa_pkg::XW'(1);
    assign nonempty = r_nz && (start_x < eff_x);
    assign fix_zero = (r_act == bfa_pkg::ACT_REG_FREE) && (r_eff != '0);
    assign first_w  = (r_act == bfa_pkg::ACT_ALLOC)
                    ? '0 : start_x[bfa_pkg::BLK_W-1:bfa_pkg::BIT_W];

    assign last_word = (r_cw == r_last);
    assign lo   = (r_cw == r_first) ? r_lo : '0;
    assign hi   = last_word ? r_hi : '1;
    assign mask = (ONES << lo) & (ONES >> (bfa_pkg::BIT_W'(bfa_pkg::WORD_BITS - 1) - hi));
    assign k    = (bfa_pkg::BIT_W+1)'(hi) - (bfa_pkg::BIT_W+1)'(lo) + (bfa_pkg::BIT_W+1)'(1);

    // Lowest clear bit inside the window: isolate it, then encode the one-hot.
    assign cand       = ~i_mem_rdata & mask;
    assign iso        = cand & (~cand + bfa_pkg::WORD_BITS'(1));
    assign found      = |cand;
    assign alloc_word = i_mem_rdata | iso;
    assign reg_word   = (r_act == bfa_pkg::ACT_REG_USED) ? (i_mem_rdata | mask)
                                                         : (i_mem_rdata & ~mask);

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
            if (iso[i]) begin
                hit_idx = hit_idx | bfa_pkg::BIT_W'(i);
            end
        end
    end

    assign up_sum = {1'b0, r_count} + (bfa_pkg::CNT_W+1)'(k);
    assign cnt_up = (up_sum > {1'b0, r_eff}) ? r_eff : up_sum[bfa_pkg::CNT_W-1:0];
    assign cnt_dn = (r_count > bfa_pkg::CNT_W'(k)) ? r_count - bfa_pkg::CNT_W'(k) : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfa_pkg::ST_FILL: begin
                if (r_fill == bfa_pkg::WORD_AW'(bfa_pkg::MAP_WORDS - 1)) begin
                    n_state = bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bfa_pkg::ST_PREP;
                end
            end
            bfa_pkg::ST_PREP: begin
                if (r_act == bfa_pkg::ACT_ALLOC) begin
                    n_state = (r_count >= r_eff) ? bfa_pkg::ST_DONE : bfa_pkg::ST_SCAN;
                end else if (nonempty) begin
                    n_state = bfa_pkg::ST_REGION;
                end else begin
                    n_state = fix_zero ? bfa_pkg::ST_FIX_RD : bfa_pkg::ST_DONE;
                end
            end
            bfa_pkg::ST_SCAN: begin
                if (r_qv && (found || last_word)) begin
                    n_state = bfa_pkg::ST_DONE;
                end
            end
            bfa_pkg::ST_REGION: begin
                if (r_qv && last_word) begin
                    n_state = fix_zero ? bfa_pkg::ST_FIX_RD : bfa_pkg::ST_DONE;
                end
            end
            bfa_pkg::ST_FIX_RD: n_state = bfa_pkg::ST_FIX_WR;
            bfa_pkg::ST_FIX_WR: n_state = bfa_pkg::ST_DONE;
            bfa_pkg::ST_DONE: begin
                if (i_res_ack) begin
                    n_state = bfa_pkg::ST_IDLE;
                end
            end
            default: n_state = bfa_pkg::ST_IDLE;
        endcase
        if (i_cfg_wr_en) begin
            n_state = bfa_pkg::ST_FILL;
        end
    end

    // Memory port and handshake outputs
    always_comb begin
        o_mem_req       = '0;
        o_in_ready      = 1'b0;
        o_res_valid     = 1'b0;
        unique case (r_state)
            bfa_pkg::ST_FILL: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_fill;
                o_mem_req.wdata = ONES;
            end
            bfa_pkg::ST_IDLE: o_in_ready = 1'b1;
            bfa_pkg::ST_PREP: ;
            bfa_pkg::ST_SCAN: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = r_rd;
                o_mem_req.we    = r_qv && found;
                o_mem_req.waddr = r_cw;
                o_mem_req.wdata = alloc_word;
            end
            bfa_pkg::ST_REGION: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = r_rd;
                o_mem_req.we    = r_qv;
                o_mem_req.waddr = r_cw;
                o_mem_req.wdata = reg_word;
            end
            bfa_pkg::ST_FIX_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = '0;
            end
            bfa_pkg::ST_FIX_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = '0;
                o_mem_req.wdata = i_mem_rdata | bfa_pkg::WORD_BITS'(1);
            end
            bfa_pkg::ST_DONE: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_res.status = r_status;
    assign o_res.frame  = r_frame;
    assign o_res.used   = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfa_pkg::ST_FILL;
            r_fill  <= '0;
            r_eff   <= bfa_pkg::CNT_W'(bfa_pkg::NUM_BLOCKS < 32768 ? bfa_pkg::NUM_BLOCKS : 32768);
            r_count <= bfa_pkg::CNT_W'(bfa_pkg::NUM_BLOCKS < 32768 ? bfa_pkg::NUM_BLOCKS : 32768);
            r_qv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_fill  <= '0;
                r_eff   <= cfg_eff;
                r_count <= cfg_eff;
            end else begin
                unique case (r_state)
                    bfa_pkg::ST_FILL: r_fill <= r_fill + bfa_pkg::WORD_AW'(1);
                    bfa_pkg::ST_SCAN: begin
                        if (r_qv && found) begin
                            r_count <= r_count + bfa_pkg::CNT_W'(1);
                        end
                    end
                    bfa_pkg::ST_REGION: begin
                        if (r_qv) begin
                            r_count <= (r_act == bfa_pkg::ACT_REG_USED) ? cnt_up : cnt_dn;
                        end
                    end
                    default: ;
                endcase
            end
            // Read pipeline: r_cw names the word whose data is on the memory output.
            // The first word address is loaded while preparing, from the new request.
            if (r_state == bfa_pkg::ST_SCAN || r_state == bfa_pkg::ST_REGION) begin
                r_rd <= r_rd + bfa_pkg::WORD_AW'(1);
                r_cw <= r_rd;
                r_qv <= 1'b1;
            end else begin
                r_rd <= first_w;
                r_qv <= 1'b0;
            end
        end
    end

    // Request payload
    always_ff @(posedge i_clk) begin
        if (r_state == bfa_pkg::ST_IDLE && i_in_valid) begin
            r_act    <= in_act;
            r_start  <= in_start;
            r_end    <= {1'b0, in_start} + {1'b0, in_amount};
            r_nz     <= (in_amount != '0);
            r_status <= 1'b0;
            r_frame  <= '0;
        end
        if (r_state == bfa_pkg::ST_PREP) begin
            r_last  <= lastb[bfa_pkg::BLK_W-1:bfa_pkg::BIT_W];
            r_hi    <= lastb[bfa_pkg::BIT_W-1:0];
            r_first <= first_w;
            if (r_act == bfa_pkg::ACT_ALLOC) begin
                r_lo    <= '0;
                r_status <= (r_count >= r_eff);
            end else begin
                r_lo    <= start_x[bfa_pkg::BIT_W-1:0];
            end
        end
        if (r_state == bfa_pkg::ST_SCAN && r_qv) begin
            if (found) begin
                r_frame <= bfa_pkg::ADDR_W'({r_cw, hit_idx}) << bfa_pkg::BLK_SHIFT;
            end else if (last_word) begin
                r_status <= 1'b1;
            end
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_eff)
        else $error("used count exceeds the effective total");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfa_pkg::ST_IDLE || r_state == bfa_pkg::ST_DONE) |-> !o_mem_req.we)
        else $error("bitmap written while no request is in progress");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.we && o_mem_req.re) |-> (o_mem_req.waddr != o_mem_req.raddr))
        else $error("read and write of the same bitmap word in one cycle");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfa_pkg::ST_DONE && r_act == bfa_pkg::ACT_ALLOC && !r_status)
        |-> ((r_frame >> bfa_pkg::BLK_SHIFT) < bfa_pkg::ADDR_W'(r_eff)))
        else $error("allocated block lies beyond the total");

endmodule

// ===== design/bitmap_frame_allocator_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: address, size_bytes
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: frame_address, used_blocks
// cfg       in   i_cfg_wr_en                   i_cfg_wr_data: total_blocks
//
// One request is handled at a time; the bitmap sits in one word-wide memory with one
// read and one write port. Allocate, unless the map is full, scans bitmap words from word 0
// until a clear bit is found (up to total/32 words); region actions touch each word of the
// region once, and mark-region-free then sets bit 0 of word 0 again; free touches one word.
// After reset and after each write of total_blocks the bitmap is swept to all ones,
// one word per cycle (1024 words), and no request is taken meanwhile.
// A finished result waits in the output register while the next request is accepted.

module bitmap_frame_allocator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bfa_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [1:0]                s_axis_tuser,   // [1:0] action
    input  logic [63:0]               s_axis_tdata,   // [31:0] address, [63:32] size_bytes
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic                      m_axis_tuser,   // [0] status
    output logic [47:0]               m_axis_tdata    // [31:0] frame_address, [47:32] used_blocks
);

    bfa_pkg::t_mem_req             mem_req;
    logic [bfa_pkg::WORD_BITS-1:0] mem_rdata;
    bfa_pkg::t_result              res;
    logic                          res_valid, res_ack;

    logic                          r_ov;
    bfa_pkg::t_result              r_res;

    bfa_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_address     (s_axis_tdata[31:0]),
        .i_size_bytes  (s_axis_tdata[63:32]),
        .o_res_valid   (res_valid),
        .i_res_ack     (res_ack),
        .o_res         (res),
        .o_mem_req     (mem_req),
        .i_mem_rdata   (mem_rdata)
    );

    bfa_map_ram u_map (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // The output register takes a new result when empty or emptying this cycle.
    assign res_ack = res_valid && (!r_ov || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_ack) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tdata  = {r_res.used, r_res.frame};

endmodule
